[hdl/pfd_pkg.sv]
// Package for the parameter frame deframer: phase codes, result kinds,
// frame marker bytes and shared types. No dependencies.
package pfd_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int INDEX_W = 6;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [1:0]         kind_type;

   localparam kind_type KIND_WORD  = 2'd0;
   localparam kind_type KIND_END   = 2'd1;
   localparam kind_type KIND_ERROR = 2'd2;

   localparam byte_type MARK_AB = 8'hAB;
   localparam byte_type MARK_CC = 8'hCC;
   localparam byte_type MARK_DD = 8'hDD;
   localparam byte_type MARK_FF = 8'hFF;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_PAYLOAD,
      PH_TRAILER,
      PH_EMIT,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic shift_byte;
      logic shift_word;
   } cell_ctrl_type;

endpackage

[hdl/pfd_if.sv]
// Channel interfaces of the parameter frame deframer: byte input and result output.
// Depends on pfd_pkg.
interface pfd_req_if;
   logic              valid;
   logic              ready;
   pfd_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfd_rsp_if;
   logic               valid;
   logic               ready;
   pfd_pkg::kind_type  kind;
   pfd_pkg::index_type word_index;
   logic signed [31:0] word_value;
   logic               last;

   modport source (output valid, output kind, output word_index, output word_value,
                   output last, input ready);
   modport sink   (input valid, input kind, input word_index, input word_value,
                   input last, output ready);
endinterface

[hdl/pfd_cell.sv]
// One payload cell: holds one 32-bit word, shifts bytes in at the top and
// passes whole words to its neighbor. Depends on pfd_pkg.
module pfd_cell (
   input  logic                   clock,
   input  pfd_pkg::cell_ctrl_type ctrl,
   input  pfd_pkg::byte_type      byte_in,
   input  pfd_pkg::word_type      word_in,
   output pfd_pkg::word_type      word_out
);
   import pfd_pkg::*;

   word_type word_ff;
   word_type word_in_mux;

   always_comb begin
      word_in_mux = word_ff;
      if (ctrl.shift_byte) begin
         word_in_mux = {byte_in, word_ff[WORD_W-1:BYTE_W]};
      end else if (ctrl.shift_word) begin
         word_in_mux = word_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in_mux;
   end

   assign word_out = word_ff;

endmodule

[hdl/parameter_frame_deframer.sv]
// Parameter frame deframer. Takes one received byte per cycle while the result
// slot is free, except at frame end. Header AB CC DD opens a data frame of
// PAYLOAD_WORDS*4 payload bytes closed by DD CC FF; header DD DD DD opens a
// command frame closed by FF FF FF. Payload bytes shift into a row of
// PAYLOAD_WORDS word cells. On a good data trailer the cells shift words out of
// the head of the row, one word per cycle the result side takes, with the input
// held off until the last word is out. A bad trailer gives one error result
// and hunting restarts; after a good frame all bytes are taken and dropped
// until reset. Depends on pfd_pkg, pfd_if, pfd_cell.
module parameter_frame_deframer #(
   parameter int PAYLOAD_WORDS = 19
) (
   input  logic     clock,
   input  logic     reset,
   pfd_req_if.sink  req,
   pfd_rsp_if.source rsp
);
   import pfd_pkg::*;

   localparam int PAYLOAD_BYTES = PAYLOAD_WORDS * 4;
   localparam int COUNT_W       = $clog2(PAYLOAD_BYTES + 1);

   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type LAST_BYTE = count_type'(PAYLOAD_BYTES - 1);
   localparam index_type LAST_WORD = index_type'(PAYLOAD_WORDS - 1);
   localparam count_type TWO       = count_type'(2);

   phase_type     phase_ff, phase_in;
   count_type     count_ff, count_in;
   byte_type      hdr0_ff, hdr0_in, hdr1_ff, hdr1_in;
   byte_type      trl0_ff, trl0_in, trl1_ff, trl1_in;
   logic          is_data_ff, is_data_in;
   index_type     emit_ff, emit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   kind_type      rsp_kind_ff, rsp_kind_in;
   index_type     rsp_index_ff, rsp_index_in;
   word_type      rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;

   cell_ctrl_type cell_ctrl;
   word_type      cell_word [PAYLOAD_WORDS+1];

   logic          slot_free;
   logic          accept;
   logic          head_full;
   logic          data_hdr, cmd_hdr, data_trl, cmd_trl;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = slot_free && (phase_ff != PH_EMIT);
   assign accept    = req.valid && req.ready;
   assign head_full = (count_ff >= TWO);

   assign data_hdr = (hdr0_ff == MARK_AB) && (hdr1_ff == MARK_CC) && (req.rx_byte == MARK_DD);
   assign cmd_hdr  = (hdr0_ff == MARK_DD) && (hdr1_ff == MARK_DD) && (req.rx_byte == MARK_DD);
   assign data_trl = (trl0_ff == MARK_DD) && (trl1_ff == MARK_CC) && (req.rx_byte == MARK_FF);
   assign cmd_trl  = (trl0_ff == MARK_FF) && (trl1_ff == MARK_FF) && (req.rx_byte == MARK_FF);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (accept && head_full) begin
               if (data_hdr) begin
                  phase_in = PH_PAYLOAD;
               end else if (cmd_hdr) begin
                  phase_in = PH_TRAILER;
               end
            end
         end
         PH_PAYLOAD: begin
            if (accept && count_ff == LAST_BYTE) begin
               phase_in = PH_TRAILER;
            end
         end
         PH_TRAILER: begin
            if (accept && head_full) begin
               if (is_data_ff) begin
                  phase_in = data_trl ? PH_EMIT : PH_HUNT;
               end else begin
                  phase_in = cmd_trl ? PH_DONE : PH_HUNT;
               end
            end
         end
         PH_EMIT: begin
            if (slot_free && emit_ff == LAST_WORD) begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   // datapath and result slot
   always_comb begin
      count_in     = count_ff;
      hdr0_in      = hdr0_ff;
      hdr1_in      = hdr1_ff;
      trl0_in      = trl0_ff;
      trl1_in      = trl1_ff;
      is_data_in   = is_data_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      cell_ctrl    = '0;
      case (phase_ff)
         PH_HUNT: begin
            if (accept) begin
               if (!head_full) begin
                  if (count_ff == '0) begin
                     hdr0_in = req.rx_byte;
                  end else begin
                     hdr1_in = req.rx_byte;
                  end
                  count_in = count_ff + count_type'(1);
               end else if (data_hdr || cmd_hdr) begin
                  is_data_in = data_hdr;
                  count_in   = '0;
               end else begin
                  hdr0_in = hdr1_ff;
                  hdr1_in = req.rx_byte;
               end
            end
         end
         PH_PAYLOAD: begin
            if (accept) begin
               cell_ctrl.shift_byte = 1'b1;
               count_in = (count_ff == LAST_BYTE) ? '0 : count_ff + count_type'(1);
            end
         end
         PH_TRAILER: begin
            if (accept) begin
               if (!head_full) begin
                  if (count_ff == '0) begin
                     trl0_in = req.rx_byte;
                  end else begin
                     trl1_in = req.rx_byte;
                  end
                  count_in = count_ff + count_type'(1);
               end else if (is_data_ff && data_trl) begin
                  count_in = '0;
                  emit_in  = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = '0;
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  count_in     = '0;
                  if (!is_data_ff && cmd_trl) begin
                     rsp_kind_in = KIND_END;
                  end else begin
                     rsp_kind_in = KIND_ERROR;
                     hdr0_in     = '0;
                     hdr1_in     = '0;
                     trl0_in     = '0;
                     trl1_in     = '0;
                  end
               end
            end
         end
         PH_EMIT: begin
            if (slot_free) begin
               cell_ctrl.shift_word = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_WORD;
               rsp_index_in = emit_ff;
               rsp_value_in = cell_word[0];
               rsp_last_in  = (emit_ff == LAST_WORD);
               emit_in      = (emit_ff == LAST_WORD) ? '0 : emit_ff + index_type'(1);
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         hdr0_ff      <= '0;
         hdr1_ff      <= '0;
         trl0_ff      <= '0;
         trl1_ff      <= '0;
         is_data_ff   <= 1'b0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         hdr0_ff      <= hdr0_in;
         hdr1_ff      <= hdr1_in;
         trl0_ff      <= trl0_in;
         trl1_ff      <= trl1_in;
         is_data_ff   <= is_data_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign cell_word[PAYLOAD_WORDS] = '0;

   for (genvar i = 0; i < PAYLOAD_WORDS; i++) begin : g_cell
      byte_type byte_from_next;

      if (i == PAYLOAD_WORDS - 1) begin : g_tail
         assign byte_from_next = req.rx_byte;
      end else begin : g_body
         assign byte_from_next = cell_word[i+1][BYTE_W-1:0];
      end

      pfd_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .byte_in  (byte_from_next),
         .word_in  (cell_word[i+1]),
         .word_out (cell_word[i])
      );
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = rsp_kind_ff;
   assign rsp.word_index = rsp_index_ff;
   assign rsp.word_value = signed'(rsp_value_ff);
   assign rsp.last       = rsp_last_ff;

endmodule

[dv/tb_parameter_frame_deframer.sv]
// Testbench for parameter_frame_deframer: drives byte streams of headers, payloads and
// trailers, predicts the result words and checks them in order.
// Depends on pfd_pkg, pfd_if and the deframer RTL.
module tb_parameter_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import pfd_pkg::*;

   localparam int PAYLOAD_WORDS = 19;
   localparam int PAYLOAD_BYTES = PAYLOAD_WORDS * 4;
   localparam int ITEM_TARGET   = 280;
   localparam int TAIL_BYTES    = PAYLOAD_BYTES + 20;
   localparam int DRAIN_CYCLES  = 4 * PAYLOAD_WORDS + 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      kind_type  kind;
      index_type word_index;
      word_type  word_value;
      logic      last;
   } frame_result_type;

   logic clock;
   logic reset;

   pfd_req_if req_bus ();
   pfd_rsp_if rsp_bus ();

   parameter_frame_deframer #(.PAYLOAD_WORDS(PAYLOAD_WORDS)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   byte_type         rx_stream [$];
   frame_result_type awaited_results [$];
   int               bytes_total;
   int               bytes_taken;
   int               mismatch_count;
   int               cycle_count;
   int               hold_left;
   logic             hold_fired;
   logic             calm;

   phase_type dfr_phase;
   int        dfr_count;
   byte_type  dfr_header [2];
   byte_type  dfr_trailer [2];
   logic      dfr_is_data;
   byte_type  dfr_payload [PAYLOAD_BYTES];

   byte_type opening_bytes [22] = '{
      8'h00, MARK_FF, 8'h80, 8'h7F, MARK_AB, MARK_CC, 8'hDE,
      MARK_DD, MARK_DD, MARK_CC, MARK_DD, MARK_DD, MARK_DD,
      MARK_FF, MARK_FF, 8'hFE,
      MARK_DD, MARK_DD, MARK_DD, MARK_DD, MARK_CC, MARK_FF
   };

   assign calm = (bytes_taken >= 150) && (bytes_taken < 300);

   function automatic word_type extreme_word(input int sel);
      case (sel)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic void restart_hunt();
      dfr_phase      = PH_HUNT;
      dfr_count      = 0;
      dfr_header[0]  = '0;
      dfr_header[1]  = '0;
      dfr_trailer[0] = '0;
      dfr_trailer[1] = '0;
   endfunction

   function automatic void deframe_byte(input byte_type b);
      frame_result_type r;
      case (dfr_phase)
         PH_HUNT: begin
            if (dfr_count < 2) begin
               dfr_header[dfr_count] = b;
               dfr_count++;
            end else if (dfr_header[0] == MARK_AB && dfr_header[1] == MARK_CC &&
                         b == MARK_DD) begin
               dfr_phase   = PH_PAYLOAD;
               dfr_is_data = 1'b1;
               dfr_count   = 0;
            end else if (dfr_header[0] == MARK_DD && dfr_header[1] == MARK_DD &&
                         b == MARK_DD) begin
               dfr_phase   = PH_TRAILER;
               dfr_is_data = 1'b0;
               dfr_count   = 0;
            end else begin
               dfr_header[0] = dfr_header[1];
               dfr_header[1] = b;
            end
         end
         PH_PAYLOAD: begin
            dfr_payload[dfr_count] = b;
            dfr_count++;
            if (dfr_count >= PAYLOAD_BYTES) begin
               dfr_phase = PH_TRAILER;
               dfr_count = 0;
            end
         end
         PH_TRAILER: begin
            if (dfr_count < 2) begin
               dfr_trailer[dfr_count] = b;
               dfr_count++;
            end else if (dfr_is_data && dfr_trailer[0] == MARK_DD &&
                         dfr_trailer[1] == MARK_CC && b == MARK_FF) begin
               for (int i = 0; i < PAYLOAD_WORDS; i++) begin
                  r.kind       = KIND_WORD;
                  r.word_index = index_type'(i);
                  r.word_value = {dfr_payload[4*i+3], dfr_payload[4*i+2],
                                  dfr_payload[4*i+1], dfr_payload[4*i]};
                  r.last       = (i == PAYLOAD_WORDS - 1);
                  awaited_results.push_back(r);
               end
               dfr_phase = PH_DONE;
               dfr_count = 0;
            end else if (!dfr_is_data && dfr_trailer[0] == MARK_FF &&
                         dfr_trailer[1] == MARK_FF && b == MARK_FF) begin
               r = '{kind: KIND_END, word_index: '0, word_value: '0, last: 1'b1};
               awaited_results.push_back(r);
               dfr_phase = PH_DONE;
               dfr_count = 0;
            end else begin
               r = '{kind: KIND_ERROR, word_index: '0, word_value: '0, last: 1'b1};
               awaited_results.push_back(r);
               restart_hunt();
            end
         end
         default: ;
      endcase
   endfunction

   task automatic queue_frame(input bit is_data, input bit good);
      byte_type tail [3];
      word_type w;
      int       spot;
      if (is_data) begin
         rx_stream.push_back(MARK_AB);
         rx_stream.push_back(MARK_CC);
         rx_stream.push_back(MARK_DD);
         for (int i = 0; i < PAYLOAD_WORDS; i++) begin
            w = $urandom;
            if (good && i < 4)
               w = extreme_word(i);
            else if ($urandom_range(3) == 0)
               w = extreme_word($urandom_range(3));
            for (int k = 0; k < 4; k++)
               rx_stream.push_back(w[8*k +: 8]);
         end
         tail = '{MARK_DD, MARK_CC, MARK_FF};
      end else begin
         repeat (3) rx_stream.push_back(MARK_DD);
         tail = '{MARK_FF, MARK_FF, MARK_FF};
      end
      if (!good) begin
         spot = $urandom_range(3);
         if (spot == 3) begin
            if (is_data)
               tail = '{MARK_FF, MARK_FF, MARK_FF};
            else
               tail = '{MARK_DD, MARK_CC, MARK_FF};
         end else begin
            tail[spot] = tail[spot] ^ byte_type'($urandom_range(255, 1));
         end
      end
      for (int k = 0; k < 3; k++)
         rx_stream.push_back(tail[k]);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      int       roll;
      byte_type lead;
      byte_type third;
      bit       last_kind;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready  = 1'b0;
      restart_hunt();
      dfr_is_data    = 1'b0;
      bytes_taken    = 0;
      mismatch_count = 0;

      foreach (opening_bytes[i])
         rx_stream.push_back(opening_bytes[i]);
      while (rx_stream.size() < ITEM_TARGET - TAIL_BYTES) begin
         roll = $urandom_range(99);
         if (roll < 60) begin
            queue_frame(1'b0, 1'b0);
         end else if (roll < 75) begin
            queue_frame(1'b1, 1'b0);
         end else if (roll < 88) begin
            repeat ($urandom_range(6, 1)) rx_stream.push_back(byte_type'($urandom));
         end else begin
            lead  = $urandom_range(1) ? MARK_AB : MARK_DD;
            third = byte_type'($urandom);
            if (third == MARK_DD)
               third = 8'h00;
            rx_stream.push_back(lead);
            rx_stream.push_back(lead == MARK_AB ? MARK_CC : MARK_DD);
            rx_stream.push_back(third);
         end
      end
      last_kind = $urandom_range(1);
      queue_frame(last_kind, 1'b1);
      repeat ($urandom_range(8, 2)) rx_stream.push_back(byte_type'($urandom));
      queue_frame(!last_kind, 1'b1);
      bytes_total = rx_stream.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (bytes_taken != bytes_total) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (rx_stream.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
            req_bus.valid   <= 1'b1;
            req_bus.rx_byte <= rx_stream.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_fired <= 1'b0;
      end else if (!hold_fired && bytes_taken >= 40) begin
         hold_left  <= HOLD_CYCLES;
         hold_fired <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 23);
   end

   always @(posedge clock) begin : result_check
      frame_result_type seen;
      frame_result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            deframe_byte(req_bus.rx_byte);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.kind       = rsp_bus.kind;
            seen.word_index = rsp_bus.word_index;
            seen.word_value = rsp_bus.word_value;
            seen.last       = rsp_bus.last;
            if (awaited_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: kind %0d index %0d value %h last %b",
                           seen.kind, seen.word_index, seen.word_value, seen.last);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               if (seen.kind !== want.kind || seen.word_index !== want.word_index ||
                   seen.word_value !== want.word_value || seen.last !== want.last) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected %0d %0d %h %b, got %0d %0d %h %b",
                              want.kind, want.word_index, want.word_value, want.last,
                              seen.kind, seen.word_index, seen.word_value, seen.last);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

endmodule
